@@ src/jcn_pkg.sv @@
// ----------------------------------------------------------------------------
// jcn_pkg
// Types and constants shared by the joystick cursor navigator.
// ----------------------------------------------------------------------------
package jcn_pkg;

	typedef struct packed {
		logic [9:0] x_sample;
		logic [9:0] y_sample;
		logic       switch_level;
	} sample_t;

	typedef struct packed {
		logic       button_pushed;
		logic [5:0] cursor_column;
		logic [1:0] cursor_line;
		logic [7:0] menu_top;
		logic       armed;
	} result_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THRESHOLD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MENU_ENTRIES   = 3'd4;

	localparam logic [9:0] HIGH_THRESHOLD_RST = 10'd800;
	localparam logic [9:0] LOW_THRESHOLD_RST  = 10'd200;
	localparam logic [6:0] COLUMN_COUNT_RST   = 7'd16;
	localparam logic [2:0] ROW_COUNT_RST      = 3'd2;
	localparam logic [7:0] MENU_ENTRIES_RST   = 8'd10;

	localparam logic [6:0] MAX_COLUMNS = 7'd64;
	localparam logic [2:0] MAX_ROWS    = 3'd4;

endpackage

@@ src/joystick_cursor_navigator.sv @@
// ----------------------------------------------------------------------------
// joystick_cursor_navigator
// Turns joystick samples into cursor moves, menu scrolling and press pulses.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one beat per joystick reading (x, y, switch level).
//   result channel: one beat per sample, giving the press pulse, cursor
//   column and row, menu top and armed flag after that sample.
//   cfg port: write cfg_data to register cfg_index when cfg_write is high;
//   write only while no sample is in flight. Unknown indexes are ignored.
// Path: a sample accepted into the input register passes through the
//   compare and clamp logic into the result register; result_stall can
//   hold it in the input register in between.
// Throughput: one sample per cycle while the result is not stalled; the
//   compare/clamp pass and the state update both complete within the single stage.
// Reset: cursor and menu top go to 0, the block is armed, registers take
//   their default values and both pipeline registers are emptied.
// Stall: when result_stall holds the result register, the input register
//   keeps its sample and sample_stall rises once it is occupied; nothing is
//   dropped.
// ----------------------------------------------------------------------------
module joystick_cursor_navigator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  jcn_pkg::sample_t                     sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output jcn_pkg::result_t                     result,
	input  logic                                 cfg_write,
	input  logic [jcn_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [jcn_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import jcn_pkg::*;

	logic [9:0] high_threshold_q;
	logic [9:0] low_threshold_q;
	logic [6:0] column_count_q;
	logic [2:0] row_count_q;
	logic [7:0] menu_entries_q;

	logic       armed_q;
	logic [5:0] column_q;
	logic [1:0] row_q;
	logic [7:0] scroll_q;

	logic       valid_s1;
	sample_t    sample_s1;
	logic       result_valid_q;
	result_t    result_q;

	logic       advance;
	logic       pushed_d;
	logic       armed_d;
	logic [5:0] column_d;
	logic [1:0] row_d;
	logic [7:0] scroll_d;
	logic [5:0] last_column;
	logic [1:0] last_row;
	logic [7:0] scroll_limit;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_threshold_q <= HIGH_THRESHOLD_RST;
			low_threshold_q  <= LOW_THRESHOLD_RST;
			column_count_q   <= COLUMN_COUNT_RST;
			row_count_q      <= ROW_COUNT_RST;
			menu_entries_q   <= MENU_ENTRIES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HIGH_THRESHOLD: high_threshold_q <= cfg_data;
				CFG_LOW_THRESHOLD:  low_threshold_q  <= cfg_data;
				CFG_COLUMN_COUNT:   column_count_q   <= cfg_data[6:0];
				CFG_ROW_COUNT:      row_count_q      <= cfg_data[2:0];
				CFG_MENU_ENTRIES:   menu_entries_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	// clamp limits derived from the screen and menu sizes
	always_comb begin
		logic [2:0] rows;
		if (column_count_q == 7'd0) begin
			last_column = 6'd0;
		end else if (column_count_q > MAX_COLUMNS) begin
			last_column = 6'd63;
		end else begin
			last_column = 6'(column_count_q - 7'd1);
		end
		if (row_count_q == 3'd0) begin
			last_row = 2'd0;
		end else if (row_count_q > MAX_ROWS) begin
			last_row = 2'd3;
		end else begin
			last_row = 2'(row_count_q - 3'd1);
		end
		rows = {1'b0, last_row} + 3'd1;
		scroll_limit = (menu_entries_q > {5'd0, rows}) ?
			8'(menu_entries_q - {5'd0, rows}) : 8'd0;
	end

	// priority: press, row up, row down, column left, column right; when disarmed, re-arm once centred and released
	always_comb begin
		logic [9:0] x;
		logic [9:0] y;
		x = sample_s1.x_sample;
		y = sample_s1.y_sample;
		pushed_d = 1'b0;
		armed_d  = armed_q;
		column_d = column_q;
		row_d    = row_q;
		scroll_d = scroll_q;
		if (armed_q) begin
			if (!sample_s1.switch_level) begin
				pushed_d = 1'b1;
				armed_d  = 1'b0;
			end else if (x > high_threshold_q) begin
				if (row_q == 2'd0) begin
					if (scroll_q != 8'd0) scroll_d = scroll_q - 8'd1;
				end else begin
					row_d = row_q - 2'd1;
				end
				armed_d = 1'b0;
			end else if (x < low_threshold_q) begin
				if (({1'b0, row_q} + 3'd1) > {1'b0, last_row}) begin
					row_d = last_row;
					if (scroll_q < scroll_limit) scroll_d = scroll_q + 8'd1;
				end else begin
					row_d = row_q + 2'd1;
				end
				armed_d = 1'b0;
			end else if (y < low_threshold_q) begin
				if (column_q != 6'd0) column_d = column_q - 6'd1;
				armed_d = 1'b0;
			end else if (y > high_threshold_q) begin
				column_d = (({1'b0, column_q} + 7'd1) > {1'b0, last_column}) ?
					last_column : column_q + 6'd1;
				armed_d = 1'b0;
			end
		end else if (y < high_threshold_q && y > low_threshold_q &&
		             x < high_threshold_q && x > low_threshold_q &&
		             sample_s1.switch_level) begin
			armed_d = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b1;
			column_q <= 6'd0;
			row_q    <= 2'd0;
			scroll_q <= 8'd0;
		end else if (advance) begin
			armed_q  <= armed_d;
			column_q <= column_d;
			row_q    <= row_d;
			scroll_q <= scroll_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_valid_q || !result_stall) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.button_pushed <= pushed_d;
			result_q.cursor_column <= column_d;
			result_q.cursor_line   <= row_d;
			result_q.menu_top      <= scroll_d;
			result_q.armed         <= armed_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a press always disarms
	a_push_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.button_pushed && result.armed))
		else $error("press reported while still armed");

	// input side only stalls with an occupied input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// a disarmed sample never moves the cursor or the menu
	a_disarmed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !armed_q |=> column_q == $past(column_q) &&
			row_q == $past(row_q) && scroll_q == $past(scroll_q))
		else $error("cursor moved while disarmed");

	// state only changes when a sample passes the stage
	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(armed_q) && $stable(column_q) && $stable(scroll_q))
		else $error("state changed without a sample");

endmodule
